/* src/brte_pkg.sv */
package brte_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int CMP_W      = 32;

   typedef enum logic [1:0] {
      CMD_BEACON = 2'd0,
      CMD_CONG   = 2'd1,
      CMD_PURGE  = 2'd2,
      CMD_DATA   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RSP_NONE     = 3'd0,
      RSP_INSERTED = 3'd1,
      RSP_UPDATED  = 3'd2,
      RSP_OWN      = 3'd3,
      RSP_FULL     = 3'd4,
      RSP_NOROUTE  = 3'd5,
      RSP_FAILED   = 3'd6,
      RSP_STALE    = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      RS_FRESH   = 2'd0,
      RS_FAILED  = 2'd1,
      RS_EXPIRED = 2'd2
   } rstate_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_ADDRESS   = 1'd0,
      CSR_ROUTE_LIFETIME = 1'd1
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_OWN,
      S_SCAN,
      S_SEQ,
      S_HOP,
      S_NH,
      S_HCHG,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] dest;
      logic [31:0] seq;
      logic [15:0] next_hop;
      logic [7:0]  hops;
      rstate_type  rstate;
      logic [31:0] expiry;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic             set_valid;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

   function automatic logic [7:0] bump_hops(input logic [7:0] h);
      bump_hops = (h == 8'hFF) ? 8'hFF : h + 8'd1;
   endfunction

endpackage

/* src/brte_cmp.sv */
module brte_cmp
   import brte_pkg::*;
(
   input  logic [CMP_W-1:0] op_a,
   input  logic [CMP_W-1:0] op_b,
   output logic             cmp_eq,
   output logic             cmp_lt
);

   // Unsigned magnitude compare shared by the own, scan, sequence, hop and next-hop steps of the sequencer.
   assign cmp_eq = (op_a == op_b);
   assign cmp_lt = (op_a < op_b);

endmodule

/* src/brte_table.sv */
module brte_table
   import brte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   output logic             rd_valid,
   input  tbl_wr_type       wr
);

   entry_type         mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   entry_type         rdata_ff;
   logic              rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr.en && wr.set_valid) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data  = rdata_ff;
   assign rd_valid = rvalid_ff;

endmodule

/* src/brte_ctrl.sv */
module brte_ctrl
   import brte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  cmd_type          req_cmd,
   input  logic [15:0]      req_addr_key,
   input  logic [31:0]      req_seq_id,
   input  logic [15:0]      req_sender_hop,
   input  logic [7:0]       req_hop_count,
   input  logic             req_congested_flag,
   input  logic [31:0]      req_now_ticks,
   input  logic [15:0]      node_address,
   input  logic [31:0]      route_lifetime,
   output logic [IDX_W-1:0] tbl_rd_addr,
   input  entry_type        tbl_rd_data,
   input  logic             tbl_rd_valid,
   output tbl_wr_type       tbl_wr,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_send_out,
   output logic [15:0]      rsp_out_next_hop,
   output logic [7:0]       rsp_out_hops,
   output status_type       rsp_status
);

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [15:0]      key_ff, key_in;
   logic [31:0]      seq_ff, seq_in;
   logic [15:0]      sender_ff, sender_in;
   logic [7:0]       hops_ff, hops_in;
   logic             cong_ff, cong_in;
   logic [31:0]      now_ff, now_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_ent_ff, hit_ent_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             chg_ff, chg_in;
   logic             res_send_ff, res_send_in;
   logic [15:0]      res_nh_ff, res_nh_in;
   logic [7:0]       res_hops_ff, res_hops_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_send_ff, rsp_send_in;
   logic [15:0]      rsp_nh_ff, rsp_nh_in;
   logic [7:0]       rsp_hops_ff, rsp_hops_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic [CMP_W-1:0] op_a, op_b;
   logic             cmp_eq, cmp_lt;
   logic             issue;
   logic             scan_done;
   logic             rsp_load;

   brte_cmp u_cmp (
      .op_a   (op_a),
      .op_b   (op_b),
      .cmp_eq (cmp_eq),
      .cmp_lt (cmp_lt)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign issue       = (state_ff == S_SCAN) && (scan_ff < CNT_W'(ENTRIES));
   assign scan_done   = (state_ff == S_SCAN) && chk_vld_ff &&
                        (chk_idx_ff == IDX_W'(ENTRIES - 1));
   assign tbl_rd_addr = scan_ff[IDX_W-1:0];
   assign rsp_load    = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // Operand selection for the shared comparator.
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_OWN: begin
            op_a = {16'd0, key_ff};
            op_b = {16'd0, node_address};
         end
         S_SCAN: begin
            unique case (cmd_ff)
               CMD_CONG: begin
                  op_a = {16'd0, tbl_rd_data.next_hop};
                  op_b = {16'd0, key_ff};
               end
               CMD_PURGE: begin
                  op_a = tbl_rd_data.expiry;
                  op_b = now_ff;
               end
               CMD_BEACON, CMD_DATA: begin
                  op_a = {16'd0, tbl_rd_data.dest};
                  op_b = {16'd0, key_ff};
               end
            endcase
         end
         S_SEQ: begin
            op_a = seq_ff;
            op_b = hit_ent_ff.seq;
         end
         S_HOP, S_HCHG: begin
            op_a = {24'd0, hops_ff};
            op_b = {24'd0, hit_ent_ff.hops};
         end
         S_NH: begin
            op_a = {16'd0, sender_ff};
            op_b = {16'd0, hit_ent_ff.next_hop};
         end
         S_IDLE, S_WRITE, S_RESP: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_cmd == CMD_BEACON) ? S_OWN : S_SCAN;
            end
         end
         S_OWN: begin
            state_in = cmp_eq ? S_RESP : S_SCAN;
         end
         S_SCAN: begin
            if (scan_done) begin
               if (cmd_ff != CMD_BEACON) begin
                  state_in = S_RESP;
               end else if (hit_in) begin
                  state_in = S_SEQ;
               end else if (free_in) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SEQ: begin
            if (!cmp_lt && !cmp_eq) begin
               state_in = S_NH;
            end else if (cmp_eq) begin
               state_in = S_HOP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_HOP: begin
            state_in = cmp_lt ? S_WRITE : S_RESP;
         end
         S_NH: begin
            state_in = S_HCHG;
         end
         S_HCHG: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Datapath and table accesses.
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      seq_in        = seq_ff;
      sender_in     = sender_ff;
      hops_in       = hops_ff;
      cong_in       = cong_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      chg_in        = chg_ff;
      res_send_in   = res_send_ff;
      res_nh_in     = res_nh_ff;
      res_hops_in   = res_hops_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_send_in   = rsp_send_ff;
      rsp_nh_in     = rsp_nh_ff;
      rsp_hops_in   = rsp_hops_ff;
      rsp_status_in = rsp_status_ff;

      tbl_wr.en        = 1'b0;
      tbl_wr.set_valid = 1'b0;
      tbl_wr.addr      = chk_idx_ff;
      tbl_wr.data      = tbl_rd_data;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_cmd;
               key_in        = req_addr_key;
               seq_in        = req_seq_id;
               sender_in     = req_sender_hop;
               hops_in       = req_hop_count;
               cong_in       = req_congested_flag;
               now_in        = req_now_ticks;
               scan_in       = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               chg_in        = 1'b0;
               res_send_in   = 1'b0;
               res_nh_in     = '0;
               res_hops_in   = '0;
               res_status_in = RSP_NONE;
            end
         end
         S_OWN: begin
            if (cmp_eq) begin
               res_status_in = RSP_OWN;
            end
         end
         S_SCAN: begin
            // Addresses go out ahead of the data they return, which the table registers.
            chk_vld_in = issue;
            chk_idx_in = scan_ff[IDX_W-1:0];
            if (issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               unique case (cmd_ff)
                  CMD_CONG: begin
                     if (tbl_rd_valid && cmp_eq) begin
                        tbl_wr.en          = 1'b1;
                        tbl_wr.data.rstate = cong_ff ? RS_FAILED : RS_FRESH;
                     end
                  end
                  CMD_PURGE: begin
                     if (tbl_rd_valid && (cmp_lt || cmp_eq)) begin
                        tbl_wr.en          = 1'b1;
                        tbl_wr.data.rstate = RS_EXPIRED;
                     end
                  end
                  CMD_BEACON, CMD_DATA: begin
                     if (tbl_rd_valid && cmp_eq && !hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = chk_idx_ff;
                        hit_ent_in = tbl_rd_data;
                     end
                     if (!tbl_rd_valid && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = chk_idx_ff;
                     end
                  end
               endcase
            end
            if (scan_done) begin
               if (cmd_ff == CMD_BEACON) begin
                  if (!hit_in && !free_in) begin
                     res_status_in = RSP_FULL;
                  end else if (!hit_in) begin
                     res_status_in = RSP_INSERTED;
                     res_send_in   = 1'b1;
                     res_hops_in   = bump_hops(hops_ff);
                  end
               end else if (cmd_ff == CMD_DATA) begin
                  if (!hit_in) begin
                     res_status_in = RSP_NOROUTE;
                  end else if (hit_ent_in.rstate == RS_FAILED) begin
                     res_status_in = RSP_FAILED;
                  end else begin
                     res_send_in = 1'b1;
                     res_nh_in   = hit_ent_in.next_hop;
                  end
               end
            end
         end
         S_SEQ: begin
            if (!cmp_lt && !cmp_eq) begin
               res_status_in = RSP_UPDATED;
            end else if (cmp_lt) begin
               res_status_in = RSP_STALE;
            end
         end
         S_HOP: begin
            res_status_in = cmp_lt ? RSP_UPDATED : RSP_STALE;
         end
         S_NH: begin
            chg_in = !cmp_eq;
         end
         S_HCHG: begin
            if (chg_ff || !cmp_eq) begin
               res_send_in = 1'b1;
               res_hops_in = bump_hops(hops_ff);
            end
         end
         S_WRITE: begin
            tbl_wr.en            = 1'b1;
            tbl_wr.set_valid     = 1'b1;
            tbl_wr.addr          = hit_ff ? hit_idx_ff : free_idx_ff;
            tbl_wr.data.dest     = key_ff;
            tbl_wr.data.seq      = seq_ff;
            tbl_wr.data.next_hop = sender_ff;
            tbl_wr.data.hops     = hops_ff;
            tbl_wr.data.rstate   = RS_FRESH;
            tbl_wr.data.expiry   = now_ff + route_lifetime;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_send_in   = res_send_ff;
               rsp_nh_in     = res_nh_ff;
               rsp_hops_in   = res_hops_ff;
               rsp_status_in = res_status_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      seq_ff        <= seq_in;
      sender_ff     <= sender_in;
      hops_ff       <= hops_in;
      cong_ff       <= cong_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ent_ff    <= hit_ent_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      chg_ff        <= chg_in;
      res_send_ff   <= res_send_in;
      res_nh_ff     <= res_nh_in;
      res_hops_ff   <= res_hops_in;
      res_status_ff <= res_status_in;
      rsp_send_ff   <= rsp_send_in;
      rsp_nh_ff     <= rsp_nh_in;
      rsp_hops_ff   <= rsp_hops_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_send_out     = rsp_send_ff;
   assign rsp_out_next_hop = rsp_nh_ff;
   assign rsp_out_hops     = rsp_hops_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* src/beacon_route_table_engine_top.sv */
// One beat at a time is handled through a single comparator; every beat but an own beacon
// makes one pass over all ENTRIES table slots. The result is registered at the output, and
// the next beat can be taken while that result waits, unless an earlier result still holds
// the output register. Synchronous active-high reset clears the valid bits, the sequencer
// state and the output valid, and sets node address to 0 and route lifetime to 1000; route
// fields are not cleared, no clearing pass runs.
module beacon_route_table_engine_top
   import brte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // addr_key, seq_id, sender_hop, hop_count, congested_flag, now_ticks, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // send_out, out_next_hop, out_hops, status, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0]      node_address_ff;
   logic [31:0]      route_lifetime_ff;
   logic [IDX_W-1:0] tbl_rd_addr;
   entry_type        tbl_rd_data;
   logic             tbl_rd_valid;
   tbl_wr_type       tbl_wr;
   logic             rsp_send_out;
   logic [15:0]      rsp_out_next_hop;
   logic [7:0]       rsp_out_hops;
   status_type       rsp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff   <= 16'd0;
         route_lifetime_ff <= 32'd1000;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_NODE_ADDRESS:   node_address_ff   <= csr_wdata[15:0];
            CSR_ROUTE_LIFETIME: route_lifetime_ff <= csr_wdata[31:0];
         endcase
      end
   end

   brte_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (tbl_rd_addr),
      .rd_data  (tbl_rd_data),
      .rd_valid (tbl_rd_valid),
      .wr       (tbl_wr)
   );

   brte_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_cmd            (cmd_type'(req_tuser)),
      .req_addr_key       (req_tdata[15:0]),
      .req_seq_id         (req_tdata[47:16]),
      .req_sender_hop     (req_tdata[63:48]),
      .req_hop_count      (req_tdata[71:64]),
      .req_congested_flag (req_tdata[72]),
      .req_now_ticks      (req_tdata[104:73]),
      .node_address       (node_address_ff),
      .route_lifetime     (route_lifetime_ff),
      .tbl_rd_addr        (tbl_rd_addr),
      .tbl_rd_data        (tbl_rd_data),
      .tbl_rd_valid       (tbl_rd_valid),
      .tbl_wr             (tbl_wr),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_send_out       (rsp_send_out),
      .rsp_out_next_hop   (rsp_out_next_hop),
      .rsp_out_hops       (rsp_out_hops),
      .rsp_status         (rsp_status)
   );

   assign rsp_tdata = {4'd0, rsp_status, rsp_out_hops, rsp_out_next_hop, rsp_send_out};

endmodule

/* sim/tb_beacon_route_table_engine_top.sv */
`timescale 1ns / 100ps

import brte_pkg::*;

// Input beat fields, declared high to low so that addr_key lands in the lowest bits.
typedef struct packed {
   logic [31:0] now_ticks;
   logic        congested;
   logic [7:0]  hop_count;
   logic [15:0] sender_hop;
   logic [31:0] seq_id;
   logic [15:0] addr_key;
} route_req;

// Result beat fields, send_out in bit 0.
typedef struct packed {
   status_type  status;
   logic [7:0]  out_hops;
   logic [15:0] out_next_hop;
   logic        send_out;
} route_verdict;

class route_scoreboard;
   logic [15:0]  node_address;
   logic [31:0]  route_lifetime;
   bit           route_valid  [ENTRIES];
   logic [15:0]  route_dest   [ENTRIES];
   logic [31:0]  route_seq    [ENTRIES];
   logic [15:0]  route_nh     [ENTRIES];
   logic [7:0]   route_hops   [ENTRIES];
   rstate_type   route_state  [ENTRIES];
   logic [31:0]  route_expiry [ENTRIES];
   route_verdict pending_verdicts[$];
   int           mismatches;

   function new();
      node_address   = 16'd0;
      route_lifetime = 32'd1000;
      mismatches     = 0;
      foreach (route_valid[i]) route_valid[i] = 1'b0;
   endfunction

   function void set_register(csr_idx_type idx, logic [31:0] value);
      if (idx == CSR_NODE_ADDRESS) begin
         node_address = value[15:0];
      end else begin
         route_lifetime = value;
      end
   endfunction

   function int find_route(logic [15:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (route_valid[i] && route_dest[i] == key) return i;
      return -1;
   endfunction

   function void store_route(int i, route_req r);
      route_seq[i]    = r.seq_id;
      route_nh[i]     = r.sender_hop;
      route_hops[i]   = r.hop_count;
      route_state[i]  = RS_FRESH;
      route_expiry[i] = r.now_ticks + route_lifetime;
   endfunction

   function logic [7:0] relay_hops(logic [7:0] h);
      return (h == 8'hFF) ? h : h + 8'd1;
   endfunction

   // Works out the result of one accepted beat and moves the table on.
   function void note_request(cmd_type cmd, route_req r);
      route_verdict v;
      int           idx;
      bit           changed;
      v        = '0;
      v.status = RSP_NONE;
      case (cmd)
         CMD_BEACON: begin
            if (r.addr_key == node_address) begin
               v.status = RSP_OWN;
            end else begin
               idx = find_route(r.addr_key);
               if (idx < 0) begin
                  for (int i = ENTRIES - 1; i >= 0; i--)
                     if (!route_valid[i]) idx = i;
                  if (idx < 0) begin
                     v.status = RSP_FULL;
                  end else begin
                     route_valid[idx] = 1'b1;
                     route_dest[idx]  = r.addr_key;
                     store_route(idx, r);
                     v.status   = RSP_INSERTED;
                     v.send_out = 1'b1;
                     v.out_hops = relay_hops(r.hop_count);
                  end
               end else if (r.seq_id > route_seq[idx]) begin
                  changed = (route_nh[idx] != r.sender_hop) || (route_hops[idx] != r.hop_count);
                  store_route(idx, r);
                  v.status = RSP_UPDATED;
                  if (changed) begin
                     v.send_out = 1'b1;
                     v.out_hops = relay_hops(r.hop_count);
                  end
               end else if (r.seq_id == route_seq[idx] && r.hop_count < route_hops[idx]) begin
                  store_route(idx, r);
                  v.status = RSP_UPDATED;
               end else begin
                  v.status = RSP_STALE;
               end
            end
         end
         CMD_CONG: begin
            foreach (route_valid[i])
               if (route_valid[i] && route_nh[i] == r.addr_key)
                  route_state[i] = r.congested ? RS_FAILED : RS_FRESH;
         end
         CMD_PURGE: begin
            foreach (route_valid[i])
               if (route_valid[i] && route_expiry[i] <= r.now_ticks)
                  route_state[i] = RS_EXPIRED;
         end
         default: begin
            idx = find_route(r.addr_key);
            if (idx < 0) begin
               v.status = RSP_NOROUTE;
            end else if (route_state[idx] == RS_FAILED) begin
               v.status = RSP_FAILED;
            end else begin
               v.send_out     = 1'b1;
               v.out_next_hop = route_nh[idx];
            end
         end
      endcase
      pending_verdicts.push_back(v);
   endfunction

   task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", what);
   endtask

   task check_result(route_verdict got);
      route_verdict want;
      if (pending_verdicts.size() == 0) begin
         report("result beat with nothing outstanding");
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.send_out !== want.send_out)
         report($sformatf("send_out %0b, expected %0b", got.send_out, want.send_out));
      if (got.out_next_hop !== want.out_next_hop)
         report($sformatf("out_next_hop %0h, expected %0h", got.out_next_hop,
                          want.out_next_hop));
      if (got.out_hops !== want.out_hops)
         report($sformatf("out_hops %0d, expected %0d", got.out_hops, want.out_hops));
      if (got.status !== want.status)
         report($sformatf("status %0d, expected %0d", got.status, want.status));
   endtask
endclass

module tb_beacon_route_table_engine_top;
   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 50;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 370;
   localparam int POOL_KEYS   = 20;
   localparam int NEIGHBOURS  = 5;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   route_scoreboard sb = new();
   logic [15:0]     key_pool       [POOL_KEYS];
   logic [15:0]     neighbour_pool [NEIGHBOURS];
   logic [31:0]     tick_base;
   int              burst_left = 0;
   int              quiet_cycles = 0;

   beacon_route_table_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic route_req make_req(logic [15:0] key, logic [31:0] seq,
                                         logic [15:0] sender, logic [7:0] hops,
                                         logic cong, logic [31:0] now);
      route_req r;
      r.addr_key   = key;
      r.seq_id     = seq;
      r.sender_hop = sender;
      r.hop_count  = hops;
      r.congested  = cong;
      r.now_ticks  = now;
      return r;
   endfunction

   task automatic write_registers(input logic [15:0] node, input logic [31:0] life);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_NODE_ADDRESS;
      csr_wdata <= 32'(node);
      @(posedge clock);
      sb.set_register(CSR_NODE_ADDRESS, 32'(node));
      csr_addr  <= CSR_ROUTE_LIFETIME;
      csr_wdata <= life;
      @(posedge clock);
      sb.set_register(CSR_ROUTE_LIFETIME, life);
      csr_we <= 1'b0;
   endtask

   // The sender offers beats in bursts; a gap may open before the first beat of a burst.
   task automatic offer_beat(input cmd_type c, input route_req r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= REQ_DATA_W'(r);
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(c, r);
   endtask

   task automatic drain_table();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_hops();
      int p;
      p = $urandom_range(0, 9);
      if (p < 7) return 8'($urandom_range(0, 6));
      if (p == 7) return 8'd254;
      if (p == 8) return 8'd255;
      return 8'($urandom);
   endfunction

   // Mostly beats on a small set of destinations and neighbours, with sequence numbers
   // placed around the stored ones; the rest is unshaped noise.
   task automatic offer_random_beat();
      route_req r;
      cmd_type  c;
      int       p;
      int       idx;
      tick_base += $urandom_range(0, 40);
      p = $urandom_range(0, 99);
      if (p < 12) begin
         c = cmd_type'($urandom_range(0, 3));
         r = make_req(16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                      1'($urandom), $urandom);
      end else begin
         r = make_req(key_pool[$urandom_range(0, POOL_KEYS - 1)], $urandom,
                      neighbour_pool[$urandom_range(0, NEIGHBOURS - 1)], pick_hops(),
                      1'($urandom), tick_base);
         p = $urandom_range(0, 99);
         if (p < 50) begin
            c   = CMD_BEACON;
            idx = sb.find_route(r.addr_key);
            if (idx >= 0) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: begin
                     r.seq_id = sb.route_seq[idx] + $urandom_range(1, 3);
                     if ($urandom_range(0, 1) == 1) begin
                        r.sender_hop = sb.route_nh[idx];
                        r.hop_count  = sb.route_hops[idx];
                     end
                  end
                  3: begin
                     r.seq_id    = sb.route_seq[idx];
                     r.hop_count = sb.route_hops[idx] - 8'($urandom_range(0, 2));
                  end
                  4: r.seq_id = sb.route_seq[idx] - $urandom_range(1, 3);
                  default: r.seq_id = $urandom;
               endcase
            end
         end else if (p < 75) begin
            c = CMD_DATA;
         end else if (p < 87) begin
            c          = CMD_CONG;
            r.addr_key = neighbour_pool[$urandom_range(0, NEIGHBOURS - 1)];
         end else begin
            c           = CMD_PURGE;
            r.now_ticks = tick_base + $urandom_range(0, 1500);
         end
      end
      offer_beat(c, r);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_BEACON;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_NODE_ADDRESS;
      csr_wdata  <= '0;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      foreach (neighbour_pool[i]) neighbour_pool[i] = 16'($urandom);
      neighbour_pool[0] = 16'h0004;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the registers at their reset values.
      offer_beat(CMD_BEACON, make_req(16'h0000, 32'd9, 16'h0007, 8'd2, 1'b0, 32'd10));
      offer_beat(CMD_DATA,   make_req(16'h0005, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd10));
      offer_beat(CMD_BEACON, make_req(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1,
                                      32'hFFFF_FFFF));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd0, 16'h0002, 8'd0, 1'b0, 32'd0));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd5, 16'h0002, 8'd0, 1'b0, 32'd20));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd6, 16'h0003, 8'd0, 1'b0, 32'd30));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd7, 16'h0003, 8'd4, 1'b0, 32'd40));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd7, 16'h0004, 8'd2, 1'b0, 32'd50));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd7, 16'h0004, 8'd2, 1'b0, 32'd60));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd3, 16'h0004, 8'd1, 1'b0, 32'd70));
      offer_beat(CMD_DATA,   make_req(16'h0001, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd80));
      offer_beat(CMD_CONG,   make_req(16'h0004, 32'd0, 16'h0000, 8'd0, 1'b1, 32'd80));
      offer_beat(CMD_DATA,   make_req(16'h0001, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd90));
      offer_beat(CMD_BEACON, make_req(16'h0001, 32'd8, 16'h0004, 8'd2, 1'b0, 32'd95));
      offer_beat(CMD_CONG,   make_req(16'h0004, 32'd0, 16'h0000, 8'd0, 1'b1, 32'd96));
      offer_beat(CMD_PURGE,  make_req(16'h0000, 32'd0, 16'h0000, 8'd0, 1'b0,
                                      32'hFFFF_FFFF));
      offer_beat(CMD_DATA,   make_req(16'h0001, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd100));
      offer_beat(CMD_CONG,   make_req(16'h0004, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd100));
      offer_beat(CMD_DATA,   make_req(16'hFFFF, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd110));
      offer_beat(CMD_DATA,   make_req(16'h0001, 32'd0, 16'h0000, 8'd0, 1'b0, 32'd120));
      drain_table();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_registers(16'hFFFF, 32'd0);
            1: write_registers(key_pool[2], 32'hFFFF_FFFF);
            2: write_registers(16'($urandom), $urandom_range(200, 3000));
            3: write_registers(16'h0000, 32'd1000);
            default: write_registers(16'($urandom), $urandom);
         endcase
         tick_base = $urandom;
         repeat (PHASE_ITEMS) offer_random_beat();
         drain_table();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // The receiver stalls on its own pattern and twice holds off long enough to back the
   // block up onto its input.
   initial begin
      int   cycle;
      int   hold_left;
      int   mode;
      int   span;
      logic ready;
      cycle     = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         repeat (span) begin
            cycle++;
            if (cycle == 3000 || cycle == 25000) hold_left = 400;
            case (mode)
               0: ready = 1'b1;
               1: ready = 1'($urandom);
               2: ready = (cycle % 5) < 3;
               default: ready = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0) begin
               ready = 1'b0;
               hold_left--;
            end
            rsp_tready <= ready;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_result(route_verdict'(rsp_tdata[27:0]));
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
